// ===== src/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, codes and constants for the linear probing hash table core.
// ----------------------------------------------------------------------------
package lpht_pkg;

	// Default table depth
	localparam int TABLE_SLOTS_DEF = 128;

	// Field widths
	localparam int FUNC_W     = 2;
	localparam int KEY_W      = 31;
	localparam int REF_W      = 32;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 7;

	// Home slot reduction: key taken four bits per step, eight steps
	localparam int HASH_BITS  = 4;
	localparam int HASH_STEPS = 8;
	localparam int HCNT_W     = 3;
	localparam int HASH_W     = HASH_BITS * HASH_STEPS;

	// Operation codes
	localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// Request transaction
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		logic [REF_W-1:0]  title_ref;
		logic [REF_W-1:0]  author_ref;
		logic [REF_W-1:0]  area_ref;
	} lpht_in_t;

	// Response transaction
	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_OUT_W-1:0] slot;
		logic [REF_W-1:0]      found_title;
		logic [REF_W-1:0]      found_author;
		logic [REF_W-1:0]      found_area;
	} lpht_out_t;

	// One stored table entry (valid bit kept apart)
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [REF_W-1:0] title;
		logic [REF_W-1:0] author;
		logic [REF_W-1:0] area;
	} lpht_entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear_step;
		logic load;
		logic hash_step;
		logic probe_issue;
		logic finish;
		logic out_load;
	} lpht_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic hash_last;
		logic all_issued;
		logic vld_s1;
		logic hit_s1;
		logic last_s1;
	} lpht_sts_t;

endpackage

// ===== src/lpht_dpath.sv =====
// ----------------------------------------------------------------------------
// lpht_dpath
// Datapath: request registers, serial home slot reduction, probe address
// walk, valid and entry memories, hit compare and result registers.
// ----------------------------------------------------------------------------
module lpht_dpath #(
	parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lpht_pkg::lpht_cmd_t cmd,
	output lpht_pkg::lpht_sts_t sts,
	input  lpht_pkg::lpht_in_t  in_data,
	output lpht_pkg::lpht_out_t out_data
);

	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int RW     = SLOT_W + 1;
	localparam int CW     = $clog2(TABLE_SLOTS + 1);
	localparam int SO_W   = lpht_pkg::SLOT_OUT_W;
	localparam int HW     = lpht_pkg::HASH_W;
	localparam int HB     = lpht_pkg::HASH_BITS;
	localparam int HC_W   = lpht_pkg::HCNT_W;

	// Request registers
	logic [lpht_pkg::FUNC_W-1:0] func_q;
	logic [lpht_pkg::KEY_W-1:0]  key_q;
	logic [lpht_pkg::REF_W-1:0]  title_q;
	logic [lpht_pkg::REF_W-1:0]  author_q;
	logic [lpht_pkg::REF_W-1:0]  area_q;

	// Home slot reduction
	logic [HW-1:0]   keysh_q;
	logic [RW-1:0]   rem_q;
	logic [RW-1:0]   rem_next;
	logic [HC_W-1:0] hcnt_q;

	// Probe walk
	logic [SLOT_W-1:0] probe_addr_q;
	logic [SLOT_W-1:0] probe_next;
	logic [CW-1:0]     cnt_q;

	// Read stage
	logic                  vld_s1;
	logic                  last_s1;
	logic [SLOT_W-1:0]     addr_s1;
	logic                  rd_valid_s1;
	lpht_pkg::lpht_entry_t rd_entry_s1;
	logic                  hit;

	// Clearing pass
	logic [SLOT_W-1:0] clr_q;

	// Memories and write port
	logic                  valid_mem [TABLE_SLOTS];
	lpht_pkg::lpht_entry_t entry_mem [TABLE_SLOTS];
	logic                  val_we;
	logic [SLOT_W-1:0]     val_wa;
	logic                  val_wd;
	logic                  ent_we;
	logic                  is_ins;
	logic                  is_srch;
	logic                  is_rem;

	// Result
	lpht_pkg::lpht_out_t res_q;
	lpht_pkg::lpht_out_t out_q;

	assign is_ins  = (func_q == lpht_pkg::OP_INSERT);
	assign is_srch = (func_q == lpht_pkg::OP_SEARCH);
	assign is_rem  = (func_q == lpht_pkg::OP_REMOVE);

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= in_data.func;
			key_q    <= in_data.key;
			title_q  <= in_data.title_ref;
			author_q <= in_data.author_ref;
			area_q   <= in_data.area_ref;
		end
	end

	// Reduce four key bits per step, MSB first, modulo the table depth
	always_comb begin
		logic [RW-1:0] r;
		r = rem_q;
		for (int i = 0; i < HB; i++) begin
			r = {r[RW-2:0], keysh_q[HW-1-i]};
			if (r >= RW'(TABLE_SLOTS))
				r = r - RW'(TABLE_SLOTS);
		end
		rem_next = r;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			keysh_q <= {1'b0, in_data.key};
			rem_q   <= '0;
		end else if (cmd.hash_step) begin
			keysh_q <= {keysh_q[HW-HB-1:0], {HB{1'b0}}};
			rem_q   <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
		end else if (cmd.load) begin
			hcnt_q <= '0;
		end else if (cmd.hash_step) begin
			hcnt_q <= hcnt_q + HC_W'(1);
		end
	end

	// Advance the probe address with wrap
	assign probe_next = (probe_addr_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0
		: probe_addr_q + SLOT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_addr_q <= '0;
			cnt_q        <= '0;
		end else if (cmd.hash_step && sts.hash_last) begin
			probe_addr_q <= SLOT_W'(rem_next);
			cnt_q        <= '0;
		end else if (cmd.probe_issue) begin
			probe_addr_q <= probe_next;
			cnt_q        <= cnt_q + CW'(1);
		end
	end

	// Read stage bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.probe_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe_issue) begin
			addr_s1 <= probe_addr_q;
			last_s1 <= (cnt_q == CW'(TABLE_SLOTS - 1));
		end
	end

	// Step through every slot after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= sts.clr_last ? '0 : clr_q + SLOT_W'(1);
		end
	end

	// Match the slot read in the previous cycle
	always_comb begin
		case (func_q) inside
			lpht_pkg::OP_INSERT: hit = !rd_valid_s1;
			lpht_pkg::OP_SEARCH,
			lpht_pkg::OP_REMOVE: hit = rd_valid_s1 && (rd_entry_s1.key == key_q);
			default:             hit = 1'b0;
		endcase
	end

	// Memory write port
	assign ent_we = cmd.finish && hit && is_ins;
	assign val_we = cmd.clear_step || (cmd.finish && hit && (is_ins || is_rem));
	assign val_wa = cmd.clear_step ? clr_q : addr_s1;
	assign val_wd = !cmd.clear_step && is_ins;

	always_ff @(posedge clk) begin
		if (val_we)
			valid_mem[val_wa] <= val_wd;
		if (cmd.probe_issue)
			rd_valid_s1 <= valid_mem[probe_addr_q];
	end

	always_ff @(posedge clk) begin
		if (ent_we)
			entry_mem[addr_s1] <= '{key: key_q, title: title_q, author: author_q,
				area: area_q};
		if (cmd.probe_issue)
			rd_entry_s1 <= entry_mem[probe_addr_q];
	end

	// Build the result at the end of the walk
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (hit)
				res_q.status <= lpht_pkg::ST_OK;
			else if (is_ins)
				res_q.status <= lpht_pkg::ST_FULL;
			else
				res_q.status <= lpht_pkg::ST_MISS;
			res_q.slot <= hit ? SO_W'(addr_s1) : '0;
			if (hit && is_srch) begin
				res_q.found_title  <= rd_entry_s1.title;
				res_q.found_author <= rd_entry_s1.author;
				res_q.found_area   <= rd_entry_s1.area;
			end else begin
				res_q.found_title  <= '0;
				res_q.found_author <= '0;
				res_q.found_area   <= '0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_q <= res_q;
	end

	assign out_data = out_q;

	assign sts.clr_last   = (clr_q == SLOT_W'(TABLE_SLOTS - 1));
	assign sts.hash_last  = (hcnt_q == HC_W'(lpht_pkg::HASH_STEPS - 1));
	assign sts.all_issued = (cnt_q == CW'(TABLE_SLOTS));
	assign sts.vld_s1     = vld_s1;
	assign sts.hit_s1     = vld_s1 && hit;
	assign sts.last_s1    = last_s1;

endmodule

// ===== src/lpht_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: clearing pass, request intake, hash steps, probe walk and
// result hand-off to the output register.
// ----------------------------------------------------------------------------
module lpht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  lpht_pkg::lpht_sts_t sts,
	output lpht_pkg::lpht_cmd_t cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       walk_end;
	logic       out_free;

	assign walk_end = sts.vld_s1 && (sts.hit_s1 || sts.last_s1);
	assign out_free = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_last)
					state_d = S_PROBE;
			end
			S_PROBE: begin
				if (walk_end) begin
					cmd.finish = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.probe_issue = !sts.all_issued;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_CLEAR |=> state_q != S_CLEAR)
		else $error("clearing pass entered after it completed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.out_load)
		else $error("response register overwritten while still pending");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_issue |-> !sts.all_issued)
		else $error("probe issued beyond table depth");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && sts.all_issued) |-> sts.vld_s1)
		else $error("probe walk ran out of slots without a final compare");

	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == S_DONE && !in_ready))
		else $error("walk finished without moving to response hand-off");
`endif

endmodule

// ===== src/linear_probe_hash_table_core.sv =====
// Requests are taken one at a time: in_ready is high only while idle, and
// the core goes idle again once the response is in the output register.
// A request runs an 8-step hash, then probes one slot per cycle from its
// home slot until a match, up to TABLE_SLOTS slots; a miss or full table
// probes all TABLE_SLOTS. Reset: asynchronous; a clearing pass over every
// slot then empties the table, with in_ready low until it completes.
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing: insert, search, remove.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
	parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lpht_pkg::lpht_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lpht_pkg::lpht_out_t out_data
);

	lpht_pkg::lpht_cmd_t cmd;
	lpht_pkg::lpht_sts_t sts;

	// Sequence control
	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table storage and compare
	lpht_dpath #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

// ===== tb/lpht_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Watches the request and response channels of the hash table core. It keeps
// its own copy of the slot table, works out the response to each accepted
// request and compares every accepted response with the oldest one expected.
// ----------------------------------------------------------------------------
module lpht_checker #(
	parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  lpht_pkg::lpht_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  lpht_pkg::lpht_out_t out_data,
	output int unsigned         resp_waiting,
	output int unsigned         fail_count
);

	localparam int SO_W = lpht_pkg::SLOT_OUT_W;

	// Shadow copy of the slot table
	logic                       tbl_used   [TABLE_SLOTS];
	logic [lpht_pkg::KEY_W-1:0] tbl_key    [TABLE_SLOTS];
	logic [lpht_pkg::REF_W-1:0] tbl_title  [TABLE_SLOTS];
	logic [lpht_pkg::REF_W-1:0] tbl_author [TABLE_SLOTS];
	logic [lpht_pkg::REF_W-1:0] tbl_area   [TABLE_SLOTS];

	// Responses owed by the core, oldest first
	lpht_pkg::lpht_out_t want_resp_q [$];
	lpht_pkg::lpht_out_t want_resp;

	// Count a mismatch and print one line for it
	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] exp);
		fail_count++;
		$display("[%0t] %s: got %h, expected %h", $time, what, got, exp);
	endtask

	// Apply one request to the shadow table and return the response it earns
	function automatic lpht_pkg::lpht_out_t hash_table_apply(lpht_pkg::lpht_in_t req);
		lpht_pkg::lpht_out_t res;
		int                  home;
		int                  s;
		res        = '0;
		res.status = lpht_pkg::ST_MISS;
		home       = int'(req.key % TABLE_SLOTS);
		case (req.func) inside
		lpht_pkg::OP_INSERT: begin
			res.status = lpht_pkg::ST_FULL;
			for (int t = 0; t < TABLE_SLOTS; t++) begin
				s = (home + t) % TABLE_SLOTS;
				if (!tbl_used[s]) begin
					tbl_used[s]   = 1'b1;
					tbl_key[s]    = req.key;
					tbl_title[s]  = req.title_ref;
					tbl_author[s] = req.author_ref;
					tbl_area[s]   = req.area_ref;
					res.status    = lpht_pkg::ST_OK;
					res.slot      = SO_W'(s);
					break;
				end
			end
		end
		lpht_pkg::OP_SEARCH, lpht_pkg::OP_REMOVE: begin
			for (int t = 0; t < TABLE_SLOTS; t++) begin
				s = (home + t) % TABLE_SLOTS;
				if (tbl_used[s] && tbl_key[s] == req.key) begin
					res.status = lpht_pkg::ST_OK;
					res.slot   = SO_W'(s);
					if (req.func == lpht_pkg::OP_SEARCH) begin
						res.found_title  = tbl_title[s];
						res.found_author = tbl_author[s];
						res.found_area   = tbl_area[s];
					end else begin
						tbl_used[s] = 1'b0;
					end
					break;
				end
			end
		end
		default: begin
		end
		endcase
		return res;
	endfunction

	// Check responses first, then predict for the request taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++)
				tbl_used[i] = 1'b0;
			want_resp_q.delete();
			resp_waiting <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (want_resp_q.size() == 0) begin
					flag_mismatch("response with no request pending",
						32'(out_data.slot), 32'(0));
				end else begin
					want_resp = want_resp_q.pop_front();
					if (out_data.status !== want_resp.status)
						flag_mismatch("status", 32'(out_data.status), 32'(want_resp.status));
					if (out_data.slot !== want_resp.slot)
						flag_mismatch("slot", 32'(out_data.slot), 32'(want_resp.slot));
					if (out_data.found_title !== want_resp.found_title)
						flag_mismatch("found_title", out_data.found_title,
							want_resp.found_title);
					if (out_data.found_author !== want_resp.found_author)
						flag_mismatch("found_author", out_data.found_author,
							want_resp.found_author);
					if (out_data.found_area !== want_resp.found_area)
						flag_mismatch("found_area", out_data.found_area,
							want_resp.found_area);
				end
			end
			if (in_valid && in_ready)
				want_resp_q.push_back(hash_table_apply(in_data));
			resp_waiting <= want_resp_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the linear probing hash table core: a directed
// pass over collisions, wrap, duplicates and misses, random operation mixes
// under several idle patterns, and a fill to a full table and back.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int SLOTS       = lpht_pkg::TABLE_SLOTS_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 50;
	localparam int KW          = lpht_pkg::KEY_W;
	localparam logic [lpht_pkg::FUNC_W-1:0] OP_UNUSED = 2'd3;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	lpht_pkg::lpht_in_t  in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	lpht_pkg::lpht_out_t out_data;
	int unsigned         resp_waiting;
	int unsigned         fail_count;

	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	int            idle_cycles    = 0;
	logic [KW-1:0] key_pool [16];
	logic [KW-1:0] fill_keys [$];

	always #5 clk = ~clk;

	linear_probe_hash_table_core #(
		.TABLE_SLOTS(SLOTS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	lpht_checker #(
		.TABLE_SLOTS(SLOTS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.resp_waiting(resp_waiting),
		.fail_count  (fail_count)
	);

	// Stall the response channel at the current rate
	always @(posedge clk) begin
		out_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// End the run if no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("linear_probe_hash_table_core: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic lpht_pkg::lpht_in_t req_of(logic [lpht_pkg::FUNC_W-1:0] f,
		logic [KW-1:0] k, logic [lpht_pkg::REF_W-1:0] t, logic [lpht_pkg::REF_W-1:0] a,
		logic [lpht_pkg::REF_W-1:0] r);
		lpht_pkg::lpht_in_t req;
		req.func       = f;
		req.key        = k;
		req.title_ref  = t;
		req.author_ref = a;
		req.area_ref   = r;
		return req;
	endfunction

	// Mostly pool keys, some colliding on the same home slot, some anywhere
	function automatic logic [KW-1:0] pick_key();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return key_pool[$urandom_range(0, 15)];
		else if (pick < 85)
			return key_pool[$urandom_range(0, 15)] + KW'(SLOTS * $urandom_range(1, 4));
		else
			return KW'($urandom());
	endfunction

	function automatic lpht_pkg::lpht_in_t random_req();
		int                          pick;
		logic [lpht_pkg::FUNC_W-1:0] f;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			f = lpht_pkg::OP_INSERT;
		else if (pick < 75)
			f = lpht_pkg::OP_SEARCH;
		else if (pick < 95)
			f = lpht_pkg::OP_REMOVE;
		else
			f = OP_UNUSED;
		return req_of(f, pick_key(), $urandom(), $urandom(), $urandom());
	endfunction

	// Offer one request, after an optional idle gap, and hold it until taken
	task automatic send_req(lpht_pkg::lpht_in_t req);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 160)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold off new requests until every owed response has come back
	task automatic drain_responses();
		in_valid <= 1'b0;
		do @(posedge clk); while (resp_waiting != 0);
	endtask

	initial begin
		logic [KW-1:0] k;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, extremes, duplicates, collisions and wrap
		send_req(req_of(lpht_pkg::OP_SEARCH, 31'd5, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_REMOVE, 31'd5, 32'h0, 32'h0, 32'h0));
		send_req(req_of(OP_UNUSED, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF));
		send_req(req_of(lpht_pkg::OP_INSERT, 31'd0, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF));
		send_req(req_of(lpht_pkg::OP_INSERT, 31'h7FFFFFFF, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_INSERT, 31'd0, 32'd1, 32'd2, 32'd3));
		send_req(req_of(lpht_pkg::OP_INSERT, 31'd128, 32'hA5A5A5A5, 32'h5A5A5A5A,
			32'hC3C3C3C3));
		send_req(req_of(lpht_pkg::OP_SEARCH, 31'd0, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_REMOVE, 31'd0, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_SEARCH, 31'd0, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_SEARCH, 31'd128, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_INSERT, 31'd127, 32'h12345678, 32'h9ABCDEF0,
			32'h0F0F0F0F));
		send_req(req_of(lpht_pkg::OP_SEARCH, 31'd127, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_SEARCH, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF));
		send_req(req_of(lpht_pkg::OP_SEARCH, 31'd255, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_REMOVE, 31'h7FFFFFFF, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_REMOVE, 31'd0, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_REMOVE, 31'd128, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_REMOVE, 31'd127, 32'h0, 32'h0, 32'h0));
		send_req(req_of(lpht_pkg::OP_REMOVE, 31'd0, 32'h0, 32'h0, 32'h0));
		drain_responses();

		// Random mixes under each idle pattern, fresh key pool per phase
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
			default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			foreach (key_pool[i])
				key_pool[i] = KW'($urandom());
			repeat (PHASE_ITEMS) send_req(random_req());
			drain_responses();
		end

		// Fill past capacity, look up the keys, then take them all out
		for (int i = 0; i < SLOTS + 3; i++) begin
			k = pick_key();
			fill_keys.push_back(k);
			send_req(req_of(lpht_pkg::OP_INSERT, k, $urandom(), $urandom(), $urandom()));
		end
		repeat (20) send_req(req_of(lpht_pkg::OP_SEARCH,
			fill_keys[$urandom_range(0, SLOTS + 2)], $urandom(), $urandom(), $urandom()));
		foreach (fill_keys[i])
			send_req(req_of(lpht_pkg::OP_REMOVE, fill_keys[i], $urandom(), $urandom(),
				$urandom()));

		// Let stray responses show up before the verdict
		drain_responses();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("linear_probe_hash_table_core: match");
		else
			$display("linear_probe_hash_table_core: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lpht_pkg.sv
src/lpht_dpath.sv
src/lpht_ctrl.sv
src/linear_probe_hash_table_core.sv
tb/lpht_checker.sv
tb/tb_top.sv
